[hw/rtl/hpid_pkg.sv]
// shared types, constants and register codes of the heading pid turn controller
package hpid_pkg;

  localparam int HDG_W  = 16;
  localparam int TGT_W  = 9;
  localparam int GAIN_W = 18;
  localparam int ERR_W  = 17;
  localparam int CHG_W  = 18;
  localparam int SUM_W  = 40;
  localparam int RAW_W  = 60;
  localparam int DRV_W  = 8;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 18;

  localparam logic [HDG_W-1:0] FULL_TURN  = 16'd36000;
  localparam logic [HDG_W-1:0] HALF_TURN  = 16'd18000;
  localparam logic [HDG_W-1:0] NEAR_LIMIT = 16'd800;
  localparam logic [HDG_W-1:0] DONE_LIMIT = 16'd50;
  localparam logic [TGT_W-1:0] DEG_TURN   = 9'd360;
  localparam logic [6:0]       DEG_SCALE  = 7'd100;

  localparam logic signed [SUM_W:0] SUM_MAX = 41'sd549755813887;

  // drive = |raw| / (100 * 2^16): shift by 16, then divide by 100 via reciprocal
  localparam int               RAW_SHIFT   = 16;
  localparam logic [13:0]      QUOT_LIMIT  = 14'd10000;
  localparam logic [12:0]      RECIP_100   = 13'd5243;
  localparam int               RECIP_SHIFT = 19;
  localparam logic [6:0]       DRIVE_MAX   = 7'd100;

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_ANGLE,
    REG_RED_SIDE,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_GAIN_P_NEAR
  } reg_idx_t;

  typedef struct packed {
    logic [TGT_W-1:0]  target_angle;
    logic              red_side;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [GAIN_W-1:0] gain_p_near;
  } cfg_t;

  typedef struct packed {
    logic [HDG_W-1:0] h;
    logic [HDG_W-1:0] t;
    logic             start;
  } norm_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] e;
    logic signed [CHG_W-1:0] c;
    logic signed [SUM_W-1:0] sum;
    logic [GAIN_W-1:0]       kp;
    logic                    run;
    logic                    done;
    logic                    ccw;
  } core_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw;
    logic                    run;
    logic                    done;
    logic                    ccw;
  } raw_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive;
    logic                    ccw;
    logic                    done;
  } res_t;

endpackage

[hw/rtl/hpid_front.sv]
// input stage: heading range reduction, side mirror and target scaling
module hpid_front (
  input  logic                     clk,
  input  logic                     rst,
  input  hpid_pkg::cfg_t           cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [hpid_pkg::HDG_W-1:0] in_heading,
  input  logic                     in_start,
  output logic                     out_valid,
  input  logic                     out_ready,
  output hpid_pkg::norm_t          out_data
);
  import hpid_pkg::*;

  logic             vld;
  norm_t            data;
  logic [HDG_W-1:0] h_mod;
  logic [HDG_W-1:0] h_mir;
  logic [TGT_W-1:0] tgt_mod;
  logic [HDG_W-1:0] t_hund;

  always_comb begin
    h_mod = (in_heading >= FULL_TURN) ? in_heading - FULL_TURN : in_heading;
    if (cfg.red_side) begin
      h_mir = (h_mod < HALF_TURN) ? h_mod + HALF_TURN : h_mod - HALF_TURN;
    end else begin
      h_mir = h_mod;
    end
    tgt_mod = (cfg.target_angle >= DEG_TURN) ? cfg.target_angle - DEG_TURN
                                             : cfg.target_angle;
    t_hund  = HDG_W'(tgt_mod) * HDG_W'(DEG_SCALE);
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_valid && in_ready) begin
      data.h     <= h_mir;
      data.t     <= t_hund;
      data.start <= in_start;
    end
  end

endmodule

[hw/rtl/hpid_core.sv]
// turn state: direction choice, error with wrap rules, integrator and derivative
module hpid_core (
  input  logic            clk,
  input  logic            rst,
  input  hpid_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  hpid_pkg::norm_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output hpid_pkg::core_t out_data
);
  import hpid_pkg::*;

  logic                    vld;
  core_t                   data;

  logic                    active;
  logic                    direction_ccw;
  logic signed [SUM_W-1:0] error_sum;
  logic signed [ERR_W-1:0] prior_error;
  logic [GAIN_W-1:0]       chosen_p_gain;

  logic signed [HDG_W:0]   delta;
  logic [HDG_W-1:0]        gap;
  logic signed [HDG_W+1:0] wrap_s;
  logic [HDG_W-1:0]        wrap_abs;
  logic                    t_gt;
  logic                    t_lt;
  logic                    cw_start;
  logic                    ccw_eff;
  logic                    use_wrap;
  logic [HDG_W-1:0]        d;
  logic                    flip;
  logic signed [ERR_W-1:0] e_val;
  logic                    act_eff;
  logic                    is_done;
  logic                    run;
  logic signed [SUM_W-1:0] sum_base;
  logic signed [SUM_W:0]   sum_add;
  logic signed [SUM_W:0]   sum_clip;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [ERR_W-1:0] prior_base;
  logic signed [CHG_W-1:0] chg;
  logic [GAIN_W-1:0]       kp_eff;

  always_comb begin
    delta    = $signed({1'b0, in_data.t}) - $signed({1'b0, in_data.h});
    gap      = delta[HDG_W] ? HDG_W'(-delta) : HDG_W'(delta);
    wrap_s   = $signed({2'b00, in_data.t}) + $signed({2'b00, in_data.h})
             - $signed({2'b00, FULL_TURN});
    wrap_abs = wrap_s[HDG_W+1] ? HDG_W'(-wrap_s) : HDG_W'(wrap_s);
    t_gt     = in_data.t > in_data.h;
    t_lt     = in_data.t < in_data.h;

    cw_start = ((gap < HALF_TURN) && t_gt) || ((gap > HALF_TURN) && t_lt);
    ccw_eff  = in_data.start ? !cw_start : direction_ccw;
    use_wrap = (!ccw_eff && t_lt) || (ccw_eff && t_gt);
    d        = use_wrap ? wrap_abs : gap;

    if (ccw_eff) begin
      flip = (t_gt && (gap >= HALF_TURN)) || (t_lt && (gap < HALF_TURN));
    end else begin
      flip = (t_lt && (gap >= HALF_TURN)) || (t_gt && (gap < HALF_TURN));
    end
    e_val = flip ? $signed({1'b0, d}) : -$signed({1'b0, d});

    act_eff = in_data.start || active;
    is_done = act_eff && (d <= DONE_LIMIT);
    run     = act_eff && !is_done;

    // a start clears the history before this tick is folded in
    sum_base   = in_data.start ? '0 : error_sum;
    prior_base = in_data.start ? '0 : prior_error;
    sum_add    = (SUM_W+1)'(sum_base) + (SUM_W+1)'(e_val);
    if (sum_add > SUM_MAX) begin
      sum_clip = SUM_MAX;
    end else if (sum_add < -SUM_MAX) begin
      sum_clip = -SUM_MAX;
    end else begin
      sum_clip = sum_add;
    end
    sum_next = sum_clip[SUM_W-1:0];
    chg      = CHG_W'(e_val) - CHG_W'(prior_base);

    if (in_data.start) begin
      kp_eff = (d < NEAR_LIMIT) ? cfg.gain_p_near : cfg.gain_p;
    end else begin
      kp_eff = chosen_p_gain;
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= 1'b0;
      active        <= 1'b0;
      direction_ccw <= 1'b0;
      error_sum     <= '0;
      prior_error   <= '0;
      chosen_p_gain <= '0;
    end else begin
      if (in_ready) begin
        vld <= in_valid;
      end
      if (in_valid && in_ready) begin
        active        <= run;
        direction_ccw <= ccw_eff;
        chosen_p_gain <= kp_eff;
        error_sum     <= run ? sum_next : sum_base;
        prior_error   <= run ? e_val : prior_base;
      end
    end
    if (in_valid && in_ready) begin
      data.e    <= e_val;
      data.c    <= chg;
      data.sum  <= sum_next;
      data.kp   <= kp_eff;
      data.run  <= run;
      data.done <= is_done;
      data.ccw  <= ccw_eff;
    end
  end

endmodule

[hw/rtl/hpid_mac.sv]
// gain products in one stage, their sum in the next
module hpid_mac (
  input  logic            clk,
  input  logic            rst,
  input  hpid_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  hpid_pkg::core_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output hpid_pkg::raw_t  out_data
);
  import hpid_pkg::*;

  localparam int PE_W  = ERR_W + GAIN_W + 1;
  localparam int PC_W  = CHG_W + GAIN_W + 1;
  localparam int PLO_W = 2 * GAIN_W;
  localparam int HI_W  = SUM_W - GAIN_W;
  localparam int PHI_W = HI_W + GAIN_W + 1;

  logic                    vld_p;
  logic                    vld_r;
  logic                    ready_r;
  logic signed [PE_W-1:0]  pe;
  logic signed [PC_W-1:0]  pc;
  logic [PLO_W-1:0]        plo;
  logic signed [PHI_W-1:0] phi;
  logic                    run_p;
  logic                    done_p;
  logic                    ccw_p;
  logic signed [RAW_W-1:0] pe_x;
  logic signed [RAW_W-1:0] pc_x;
  logic signed [RAW_W-1:0] plo_x;
  logic signed [RAW_W-1:0] phi_x;
  raw_t                    data;

  // integrator term split into low 18-bit and high 22-bit parts of the sum
  always_comb begin
    pe_x  = RAW_W'(pe);
    pc_x  = RAW_W'(pc);
    plo_x = RAW_W'(plo);
    phi_x = RAW_W'(phi);
  end

  assign ready_r   = !vld_r || out_ready;
  assign in_ready  = !vld_p || ready_r;
  assign out_valid = vld_r;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        vld_p <= in_valid;
      end
      if (ready_r) begin
        vld_r <= vld_p;
      end
    end
    if (in_valid && in_ready) begin
      pe     <= PE_W'(in_data.e) * PE_W'($signed({1'b0, in_data.kp}));
      pc     <= PC_W'(in_data.c) * PC_W'($signed({1'b0, cfg.gain_d}));
      plo    <= PLO_W'(in_data.sum[GAIN_W-1:0]) * PLO_W'(cfg.gain_i);
      phi    <= PHI_W'($signed(in_data.sum[SUM_W-1:GAIN_W]))
              * PHI_W'($signed({1'b0, cfg.gain_i}));
      run_p  <= in_data.run;
      done_p <= in_data.done;
      ccw_p  <= in_data.ccw;
    end
    if (vld_p && ready_r) begin
      data.raw  <= (phi_x <<< GAIN_W) + plo_x + pe_x + pc_x;
      data.run  <= run_p;
      data.done <= done_p;
      data.ccw  <= ccw_p;
    end
  end

endmodule

[hw/rtl/hpid_scale.sv]
// raw sum to percent: truncating divide by 100*2^16, saturation, result register
module hpid_scale (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hpid_pkg::raw_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hpid_pkg::res_t out_data
);
  import hpid_pkg::*;

  localparam int Q_W    = RAW_W - RAW_SHIFT;
  localparam int X_W    = 14;
  localparam int PROD_W = X_W + 13;

  logic               vld_m;
  logic               vld_o;
  logic               ready_o;
  logic [RAW_W-1:0]   magn;
  logic [Q_W-1:0]     q16;
  logic               neg;
  logic               big;
  logic [X_W-1:0]     x;
  logic               run_m;
  logic               done_m;
  logic               ccw_m;
  logic [PROD_W-1:0]  prod;
  logic [6:0]         quot;
  logic [6:0]         mag7;
  logic signed [DRV_W-1:0] dmag;
  logic signed [DRV_W-1:0] drive_next;
  res_t               data;

  always_comb begin
    magn = in_data.raw[RAW_W-1] ? RAW_W'(-in_data.raw) : RAW_W'(in_data.raw);
    q16  = magn[RAW_W-1:RAW_SHIFT];
  end

  // exact floor(x/100) for x below 10000
  always_comb begin
    prod       = PROD_W'(x) * PROD_W'(RECIP_100);
    quot       = prod[RECIP_SHIFT+6:RECIP_SHIFT];
    mag7       = big ? DRIVE_MAX : quot;
    dmag       = $signed({1'b0, mag7});
    drive_next = run_m ? (neg ? -dmag : dmag) : '0;
  end

  assign ready_o   = !vld_o || out_ready;
  assign in_ready  = !vld_m || ready_o;
  assign out_valid = vld_o;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m <= 1'b0;
      vld_o <= 1'b0;
    end else begin
      if (in_ready) begin
        vld_m <= in_valid;
      end
      if (ready_o) begin
        vld_o <= vld_m;
      end
    end
    if (in_valid && in_ready) begin
      neg    <= in_data.raw[RAW_W-1];
      big    <= q16 >= Q_W'(QUOT_LIMIT);
      x      <= q16[X_W-1:0];
      run_m  <= in_data.run;
      done_m <= in_data.done;
      ccw_m  <= in_data.ccw;
    end
    if (vld_m && ready_o) begin
      data.drive <= drive_next;
      data.ccw   <= ccw_m;
      data.done  <= done_m;
    end
  end

endmodule

[hw/rtl/heading_pid_turn_controller_top.sv]
// heading pid turn controller: register bank, pipeline stages and stream ports
//
// Heading samples arrive on the s_axis channel, one per beat, in hundredths
// of a degree; s_axis_tuser set on a beat starts a new turn toward the
// programmed target. Every accepted beat yields exactly one m_axis beat with
// the signed drive percent, the latched direction and tlast on the beat that
// ends the turn.
// Registers are written on the cfg channel (index, data); cfg_ready is always
// high and writes are meant to happen while no samples are in flight.
// The datapath has six register stages (front, core, two in mac, two in scale).
// One sample per cycle is sustained while m_axis_tready is high; the turn
// state updates in a single stage, so consecutive samples need no gap.
// Each stage holds its beat when the next one is full, so a stalled m_axis
// side fills the pipeline from the output back before s_axis_tready drops;
// nothing is dropped or repeated.
// Synchronous reset empties the pipeline, clears the turn state and loads
// the default target and gains; s_axis_tready is high right after reset.
module heading_pid_turn_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [15:0] heading
  input  logic                          s_axis_tuser,  // [0] start_req
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // [7:0] drive, [8] turn_ccw
  output logic                          m_axis_tlast,  // done_res
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hpid_pkg::IDX_W-1:0]    cfg_index,
  input  logic [hpid_pkg::CFG_W-1:0]    cfg_data
);
  import hpid_pkg::*;

  cfg_t  cfg;
  logic  front_valid;
  logic  front_ready;
  norm_t front_data;
  logic  core_valid;
  logic  core_ready;
  core_t core_data;
  logic  mac_valid;
  logic  mac_ready;
  raw_t  mac_data;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_angle <= '0;
      cfg.red_side     <= 1'b0;
      cfg.gain_p       <= 18'd45875;
      cfg.gain_i       <= 18'd131;
      cfg.gain_d       <= 18'd5243;
      cfg.gain_p_near  <= 18'd131072;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TARGET_ANGLE: cfg.target_angle <= cfg_data[TGT_W-1:0];
        REG_RED_SIDE:     cfg.red_side     <= cfg_data[0];
        REG_GAIN_P:       cfg.gain_p       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:       cfg.gain_i       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:       cfg.gain_d       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_P_NEAR:  cfg.gain_p_near  <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hpid_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_heading (s_axis_tdata),
    .in_start   (s_axis_tuser),
    .out_valid  (front_valid),
    .out_ready  (front_ready),
    .out_data   (front_data)
  );

  hpid_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (core_valid),
    .out_ready (core_ready),
    .out_data  (core_data)
  );

  hpid_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (core_valid),
    .in_ready  (core_ready),
    .in_data   (core_data),
    .out_valid (mac_valid),
    .out_ready (mac_ready),
    .out_data  (mac_data)
  );

  hpid_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mac_valid),
    .in_ready  (mac_ready),
    .in_data   (mac_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata = {7'b0, res.ccw, res.drive};
  assign m_axis_tlast = res.done;

endmodule

[hw/rtl/hpid_checker.sv]
// port-level checks for the heading pid turn controller, bound to the top level
module hpid_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // drive never leaves the saturation band
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[7:0]) <= 8'sd100 &&
                       $signed(m_axis_tdata[7:0]) >= -8'sd100))
    else $error("drive outside +-100");

  // the beat that ends a turn carries no drive
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("nonzero drive on done beat");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result beat changed");

  // reset empties the pipeline and opens the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("pipeline not empty after reset");

endmodule

bind heading_pid_turn_controller_top hpid_checker u_hpid_checker (.*);
